// File: rtl/urlpd_pkg.sv
// Shared types, codes and byte classifiers for the URL percent decoder.
// No dependencies; used by url_percent_decoder_unit.
`default_nettype none

package urlpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // Register indexes.
    localparam logic REG_COMPONENT_MODE = 1'b0;

    // Component modes.
    localparam logic [MODE_W-1:0] MODE_PATH     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HOST     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ZONE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ESCAPE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HOST   = 2'd2;

    // Escape phases.
    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PERCENT = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DIGIT   = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TWO     = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_FIVE    = 8'h35;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [NIBBLE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        return v[NIBBLE_W-1:0];
    endfunction

    // True for any byte that may not stand in a host name.
    function automatic logic host_forbidden(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39);
        case (c)
            8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h5B, 8'h5D, 8'h3C, 8'h3E,
            8'h22:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = ok;
            end
        endcase
        return !ok;
    endfunction

endpackage

`default_nettype wire

// File: rtl/url_percent_decoder_unit.sv
// URL component percent decoder: input register, one decode step, result register.
// Depends on urlpd_pkg for codes and byte classifiers.
`default_nettype none

// Channel   | Direction | tdata                | tuser                          | tlast
// ----------+-----------+----------------------+--------------------------------+---------------
// s_axis    | in        | [7:0] in_byte        | -                              | end_of_input
// m_axis    | out       | [7:0] out_byte       | [0] byte_valid, [2:1] status   | end_of_output
// apb       | in/out    | 0x0: component_mode  | -                              | -
//
// An accepted word waits in the input register until the decode step takes it, which writes
// the escape state and the result register, from which its result is offered.
// One word is accepted in every cycle while the result side keeps taking words.
// A stalled result register holds a full input register, which holds s_axis_tready low.
// After reset the mode is path, no escape is open and no error is pending.
// An opening '%', a first hex digit or a byte after an error yields no word unless it is last.

module url_percent_decoder_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [urlpd_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  wire logic                            s_axis_tlast,   // end_of_input
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [urlpd_pkg::BYTE_W-1:0]         m_axis_tdata,   // [7:0] out_byte
    output logic [urlpd_pkg::STATUS_W:0]         m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic                                 m_axis_tlast,   // end_of_output
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [urlpd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [urlpd_pkg::DATA_W-1:0]    pwdata,
    output logic [urlpd_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);

    // Configuration register. The word index is paddr[2]; the low bits are byte lanes.
    logic [urlpd_pkg::MODE_W-1:0] mode_reg;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == urlpd_pkg::REG_COMPONENT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= urlpd_pkg::MODE_PATH;
        end
        else if (cfg_write)
        begin
            mode_reg <= pwdata[urlpd_pkg::MODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == urlpd_pkg::REG_COMPONENT_MODE)
        begin
            prdata = {{(urlpd_pkg::DATA_W - urlpd_pkg::MODE_W){1'b0}}, mode_reg};
        end
    end

    // Input register.
    logic                         in_valid_reg;
    logic [urlpd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_last_reg;

    // Result register.
    logic                           out_valid_reg;
    logic [urlpd_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                           out_bv_reg;
    logic [urlpd_pkg::STATUS_W-1:0] out_status_reg;
    logic                           out_last_reg;

    // Escape state.
    logic [urlpd_pkg::PHASE_W-1:0]  phase_reg,  phase_next;
    logic [urlpd_pkg::NIBBLE_W-1:0] nibble_reg, nibble_next;
    logic                           two_reg,    two_next;
    logic [urlpd_pkg::STATUS_W-1:0] sticky_reg, sticky_next;

    // The decode step runs when the input register holds a word and the result
    // register is free or is being emptied in this cycle.
    logic step_go;
    logic step_fire;
    logic in_take;

    assign step_go       = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && step_go;
    assign s_axis_tready = !in_valid_reg || step_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Decode step.
    logic [urlpd_pkg::BYTE_W-1:0]   step_byte;
    logic                           step_bv;
    logic [urlpd_pkg::STATUS_W-1:0] step_status;
    logic                           step_emit;
    logic [urlpd_pkg::NIBBLE_W-1:0] digit;
    logic [urlpd_pkg::BYTE_W-1:0]   decoded;
    logic                           is_25;
    logic                           hostish;

    assign digit   = urlpd_pkg::hex_value(in_byte_reg);
    assign decoded = {nibble_reg, digit};
    assign is_25   = two_reg && (in_byte_reg == urlpd_pkg::CHAR_FIVE);
    assign hostish = (mode_reg == urlpd_pkg::MODE_HOST) || (mode_reg == urlpd_pkg::MODE_ZONE);

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        two_next    = two_reg;
        sticky_next = sticky_reg;
        step_byte   = '0;
        step_bv     = 1'b0;
        step_status = urlpd_pkg::STATUS_OK;

        if (sticky_reg == urlpd_pkg::STATUS_OK)
        begin
            case (phase_reg)
                urlpd_pkg::PHASE_PERCENT:
                begin
                    if (urlpd_pkg::is_hex(in_byte_reg))
                    begin
                        nibble_next = digit;
                        two_next    = (in_byte_reg == urlpd_pkg::CHAR_TWO);
                        phase_next  = urlpd_pkg::PHASE_DIGIT;
                    end
                    else
                    begin
                        step_status = urlpd_pkg::STATUS_ESCAPE;
                    end
                end
                urlpd_pkg::PHASE_DIGIT:
                begin
                    if (urlpd_pkg::is_hex(in_byte_reg))
                    begin
                        phase_next = urlpd_pkg::PHASE_IDLE;
                        // Host names only take non-ASCII escapes, apart from the percent sign.
                        if ((mode_reg == urlpd_pkg::MODE_HOST) && !nibble_reg[3] && !is_25)
                        begin
                            step_status = urlpd_pkg::STATUS_ESCAPE;
                        end
                        else if ((mode_reg == urlpd_pkg::MODE_ZONE) && !is_25 &&
                                 (decoded != urlpd_pkg::CHAR_SPACE) &&
                                 urlpd_pkg::host_forbidden(decoded))
                        begin
                            step_status = urlpd_pkg::STATUS_ESCAPE;
                        end
                        else
                        begin
                            step_byte = decoded;
                            step_bv   = 1'b1;
                        end
                    end
                    else
                    begin
                        step_status = urlpd_pkg::STATUS_ESCAPE;
                    end
                end
                default:
                begin
                    // Outside an escape; the unused phase code behaves the same.
                    phase_next = urlpd_pkg::PHASE_IDLE;
                    if (in_byte_reg == urlpd_pkg::CHAR_PERCENT)
                    begin
                        phase_next = urlpd_pkg::PHASE_PERCENT;
                    end
                    else if (in_byte_reg == urlpd_pkg::CHAR_PLUS)
                    begin
                        step_byte = (mode_reg == urlpd_pkg::MODE_QUERY) ?
                                    urlpd_pkg::CHAR_SPACE : urlpd_pkg::CHAR_PLUS;
                        step_bv   = 1'b1;
                    end
                    else if (hostish && !in_byte_reg[7] && urlpd_pkg::host_forbidden(in_byte_reg))
                    begin
                        step_status = urlpd_pkg::STATUS_HOST;
                    end
                    else
                    begin
                        step_byte = in_byte_reg;
                        step_bv   = 1'b1;
                    end
                end
            endcase

            if (step_status != urlpd_pkg::STATUS_OK)
            begin
                sticky_next = step_status;
                phase_next  = urlpd_pkg::PHASE_IDLE;
            end
            else if (in_last_reg && (phase_next != urlpd_pkg::PHASE_IDLE))
            begin
                // The string ends inside an escape.
                step_status = urlpd_pkg::STATUS_ESCAPE;
            end
        end

        if (in_last_reg)
        begin
            phase_next  = urlpd_pkg::PHASE_IDLE;
            nibble_next = '0;
            two_next    = 1'b0;
            sticky_next = urlpd_pkg::STATUS_OK;
        end
    end

    assign step_emit = step_bv || (step_status != urlpd_pkg::STATUS_OK) || in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= urlpd_pkg::PHASE_IDLE;
            nibble_reg <= '0;
            two_reg    <= 1'b0;
            sticky_reg <= urlpd_pkg::STATUS_OK;
        end
        else if (step_fire)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            two_reg    <= two_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            out_valid_reg <= step_fire && step_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step_emit)
        begin
            out_byte_reg   <= step_byte;
            out_bv_reg     <= step_bv;
            out_status_reg <= step_status;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_status_reg, out_bv_reg};
    assign m_axis_tlast  = out_last_reg;

    // A word that carries a byte never carries an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bv_reg |-> out_status_reg == urlpd_pkg::STATUS_OK)
        else $error("decoded byte reported together with an error status");

    // Once an error is pending, no further error is reported in the same string.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && (sticky_reg != urlpd_pkg::STATUS_OK) |->
            step_status == urlpd_pkg::STATUS_OK && !step_bv)
        else $error("word decoded or error repeated after a sticky error");

    // The closing word of a string leaves the escape state clean.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_last_reg |=>
            phase_reg == urlpd_pkg::PHASE_IDLE && sticky_reg == urlpd_pkg::STATUS_OK)
        else $error("escape state not cleared at the end of a string");

    // The escape state moves only when a word is decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(phase_reg) && $stable(sticky_reg))
        else $error("escape state changed without a decode step");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder_unit: escaped strings go in on the
// input stream, decoded words are checked against a predictor, modes are set over APB.
// Depends on urlpd_pkg and rtl/url_percent_decoder_unit.sv; reads no files.

module tb;

    // Field widths taken from the package.
    localparam int unsigned BYTE_W   = urlpd_pkg::BYTE_W;
    localparam int unsigned MODE_W   = urlpd_pkg::MODE_W;
    localparam int unsigned STATUS_W = urlpd_pkg::STATUS_W;
    localparam int unsigned PHASE_W  = urlpd_pkg::PHASE_W;
    localparam int unsigned ADDR_W   = urlpd_pkg::ADDR_W;
    localparam int unsigned DATA_W   = urlpd_pkg::DATA_W;

    // Run sizing. The limit leaves a wide margin over the slowest correct run for the idling
    // patterns and the long result stall.
    localparam int unsigned RUN_LIMIT     = 200000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_CYCLES    = 10;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned RANDOM_WORDS  = 1425;
    localparam int unsigned SEGMENTS      = 12;
    localparam int unsigned SEGMENTS_PER_PHASE = 4;

    // Component modes that the package leaves unnamed. Mode seven is not a listed
    // component but the register holds it, and it decodes like a path.
    localparam logic [MODE_W-1:0] MODE_SEGMENT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_USERINFO = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FRAGMENT = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 3'd7;

    localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * urlpd_pkg::REG_COMPONENT_MODE);

    // One decoded word as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic [STATUS_W-1:0] status;
        logic                closing;
    } decoded_word_t;

    // Predicts the decoder from the accepted bytes and checks every word it sends.
    class percent_decode_scoreboard;
        localparam int unsigned MAX_REPORTS = 60;

        decoded_word_t       expected_words[$];
        logic [MODE_W-1:0]   mode;
        logic [PHASE_W-1:0]  phase;
        logic [3:0]          high_nibble;
        bit                  first_is_two;
        logic [STATUS_W-1:0] sticky;
        int unsigned         bytes_taken;
        int unsigned         results_seen;
        int unsigned         mismatches;

        function new();
            mode         = urlpd_pkg::MODE_PATH;
            phase        = urlpd_pkg::PHASE_IDLE;
            high_nibble  = '0;
            first_is_two = 1'b0;
            sticky       = urlpd_pkg::STATUS_OK;
            bytes_taken  = 0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function bit is_hex_char(logic [BYTE_W-1:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
        endfunction

        // Digits carry their value in the low nibble; both letter cases sit one above
        // a multiple of 16, so adding nine gives ten for 'A' and 'a'.
        function logic [3:0] nibble_of(logic [BYTE_W-1:0] c);
            if (c <= "9")
            begin
                return c[3:0];
            end
            return c[3:0] + 4'd9;
        endfunction

        function bit host_forbidden(logic [BYTE_W-1:0] c);
            string allowed;
            allowed = "-_.~!$&'()*+,;=:[]<>\"";
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            begin
                return 1'b0;
            end
            for (int i = 0; i < allowed.len(); i++)
            begin
                if (allowed[i] == c)
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, field, want, got);
                end
            end
        endfunction

        // Steps the predictor by one accepted byte and queues the word it causes, if any.
        function void note_byte(logic [BYTE_W-1:0] b, bit closing);
            decoded_word_t w;
            logic [BYTE_W-1:0] value;
            bit hostish;
            bit is25;
            w = '0;
            hostish = (mode == urlpd_pkg::MODE_HOST) || (mode == urlpd_pkg::MODE_ZONE);
            bytes_taken++;
            if (sticky == urlpd_pkg::STATUS_OK)
            begin
                case (phase)
                    urlpd_pkg::PHASE_PERCENT:
                    begin
                        if (is_hex_char(b))
                        begin
                            high_nibble  = nibble_of(b);
                            first_is_two = (b == urlpd_pkg::CHAR_TWO);
                            phase        = urlpd_pkg::PHASE_DIGIT;
                        end
                        else
                        begin
                            w.status = urlpd_pkg::STATUS_ESCAPE;
                        end
                    end
                    urlpd_pkg::PHASE_DIGIT:
                    begin
                        if (is_hex_char(b))
                        begin
                            value = {high_nibble, nibble_of(b)};
                            is25  = first_is_two && (b == urlpd_pkg::CHAR_FIVE);
                            phase = urlpd_pkg::PHASE_IDLE;
                            // Hosts take no escaped ASCII but the percent sign itself;
                            // zones also let an escaped space through.
                            if (mode == urlpd_pkg::MODE_HOST && !high_nibble[3] && !is25)
                            begin
                                w.status = urlpd_pkg::STATUS_ESCAPE;
                            end
                            else if (mode == urlpd_pkg::MODE_ZONE && !is25 &&
                                     value != urlpd_pkg::CHAR_SPACE && host_forbidden(value))
                            begin
                                w.status = urlpd_pkg::STATUS_ESCAPE;
                            end
                            else
                            begin
                                w.out_byte   = value;
                                w.byte_valid = 1'b1;
                            end
                        end
                        else
                        begin
                            w.status = urlpd_pkg::STATUS_ESCAPE;
                        end
                    end
                    default:
                    begin
                        phase = urlpd_pkg::PHASE_IDLE;
                        if (b == urlpd_pkg::CHAR_PERCENT)
                        begin
                            phase = urlpd_pkg::PHASE_PERCENT;
                        end
                        else if (b == urlpd_pkg::CHAR_PLUS)
                        begin
                            w.out_byte   = (mode == urlpd_pkg::MODE_QUERY) ?
                                           urlpd_pkg::CHAR_SPACE : urlpd_pkg::CHAR_PLUS;
                            w.byte_valid = 1'b1;
                        end
                        else if (hostish && !b[7] && host_forbidden(b))
                        begin
                            w.status = urlpd_pkg::STATUS_HOST;
                        end
                        else
                        begin
                            w.out_byte   = b;
                            w.byte_valid = 1'b1;
                        end
                    end
                endcase
                if (w.status != urlpd_pkg::STATUS_OK)
                begin
                    sticky = w.status;
                    phase  = urlpd_pkg::PHASE_IDLE;
                end
                else if (closing && phase != urlpd_pkg::PHASE_IDLE)
                begin
                    // The string ended inside an escape.
                    w.status = urlpd_pkg::STATUS_ESCAPE;
                end
            end
            if (w.byte_valid || w.status != urlpd_pkg::STATUS_OK || closing)
            begin
                w.closing = closing;
                expected_words.push_back(w);
            end
            if (closing)
            begin
                phase        = urlpd_pkg::PHASE_IDLE;
                high_nibble  = '0;
                first_is_two = 1'b0;
                sticky       = urlpd_pkg::STATUS_OK;
            end
        endfunction

        function void check_word(logic [BYTE_W-1:0] out_byte, logic [STATUS_W:0] flags,
                                 logic closing);
            decoded_word_t want;
            results_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected word, expected none, actual byte 0x%0h flags 0x%0h",
                         $time, out_byte, flags);
                return;
            end
            want = expected_words.pop_front();
            compare("out_byte", 32'(want.out_byte), 32'(out_byte));
            compare("byte_valid", 32'(want.byte_valid), 32'(flags[0]));
            compare("status", 32'(want.status), 32'(flags[STATUS_W:1]));
            compare("end_of_output", 32'(want.closing), 32'(closing));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata = '0;     // [7:0] in_byte
    logic                s_axis_tlast = 1'b0;   // end_of_input
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]   m_axis_tdata;          // [7:0] out_byte
    logic [STATUS_W:0]   m_axis_tuser;          // [0] byte_valid, [2:1] status
    logic                m_axis_tlast;          // end_of_output
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    percent_decode_scoreboard decode_board;

    // Idling odds in percent, changed only between phases of the run. The receiver
    // owns its long stall counter; the main sequence only asks for one.
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 86;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    logic [BYTE_W-1:0] string_bytes[$];
    logic [MODE_W-1:0] mode_plan[SEGMENTS];

    url_percent_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // Both handshakes are observed at the rising edge, where every input the testbench
    // drives has been steady for half a period.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            decode_board.note_byte(s_axis_tdata, s_axis_tlast);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            decode_board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Result side: random back-pressure, or a long stall when one is asked for.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("%0t ns: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one byte, with random gaps first, and returns at the edge that takes it.
    // The valid is only ever driven once per falling edge.
    task automatic send_byte(logic [BYTE_W-1:0] b, bit closing);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= closing;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_text(string text, bit closing);
        for (int i = 0; i < text.len(); i++)
        begin
            send_byte(text[i], closing && (i == text.len() - 1));
        end
    endtask

    // Stops the input stream, lets every expected word out, then gives the two-stage
    // pipe time to finish bytes that cause no word.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decode_board.expected_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(bit is_write, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The mode only changes with the block idle, so the predictor can follow at once.
    task automatic set_mode(logic [MODE_W-1:0] m);
        logic [DATA_W-1:0] readback;
        wait_idle();
        apb_access(1'b1, MODE_ADDR, DATA_W'(m), readback);
        decode_board.mode = m;
        apb_access(1'b0, MODE_ADDR, '0, readback);
        decode_board.compare("component_mode readback", DATA_W'(m), readback);
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
        begin
            return "0" + n;
        end
        return ($urandom_range(1) ? "A" : "a") + n - 4'd10;
    endfunction

    // Mostly bytes a host accepts, so host and zone strings often run to their end.
    function automatic logic [BYTE_W-1:0] plain_byte();
        string friendly;
        friendly = "abcxyzABCXYZ0159-._~!$&'()*,;=:[]<>";
        if ($urandom_range(2) == 0)
        begin
            return BYTE_W'($urandom_range(255));
        end
        return friendly[$urandom_range(friendly.len() - 1)];
    endfunction

    // Builds one string from tokens: literal bytes, plus signs, well-formed escapes, the
    // percent and space escapes, and now and then a broken or unfinished escape.
    task automatic send_random_string();
        int unsigned tokens;
        int unsigned pick;
        string_bytes.delete();
        tokens = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                string_bytes.push_back(plain_byte());
            end
            else if (pick < 50)
            begin
                string_bytes.push_back(urlpd_pkg::CHAR_PLUS);
            end
            else if (pick < 80)
            begin
                string_bytes.push_back(urlpd_pkg::CHAR_PERCENT);
                string_bytes.push_back(hex_char(4'($urandom_range(15))));
                string_bytes.push_back(hex_char(4'($urandom_range(15))));
            end
            else if (pick < 88)
            begin
                string_bytes.push_back(urlpd_pkg::CHAR_PERCENT);
                string_bytes.push_back(urlpd_pkg::CHAR_TWO);
                string_bytes.push_back($urandom_range(1) ? urlpd_pkg::CHAR_FIVE : "0");
            end
            else if (pick < 94)
            begin
                string_bytes.push_back(urlpd_pkg::CHAR_PERCENT);
                string_bytes.push_back(BYTE_W'($urandom_range(255)));
                string_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
            else
            begin
                string_bytes.push_back(urlpd_pkg::CHAR_PERCENT);
                if ($urandom_range(1))
                begin
                    string_bytes.push_back(hex_char(4'($urandom_range(15))));
                end
            end
        end
        for (int i = 0; i < string_bytes.size(); i++)
        begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
        end
    endtask

    // The long stall, when asked for, starts once the mode is set, so the sender keeps
    // offering bytes against a result side that takes nothing.
    task automatic run_segment(logic [MODE_W-1:0] m, bit long_stall);
        int unsigned start;
        set_mode(m);
        if (long_stall)
        begin
            hold_request = 1'b1;
        end
        start = decode_board.bytes_taken;
        while (decode_board.bytes_taken - start < RANDOM_WORDS / SEGMENTS)
        begin
            send_random_string();
        end
    endtask

    initial
    begin
        decode_board = new();
        // Every mode value appears, the two extremes among them.
        mode_plan = '{urlpd_pkg::MODE_PATH, MODE_SPARE, urlpd_pkg::MODE_HOST,
                      urlpd_pkg::MODE_QUERY, urlpd_pkg::MODE_ZONE, MODE_SEGMENT,
                      MODE_USERINFO, MODE_FRAGMENT, urlpd_pkg::MODE_HOST,
                      urlpd_pkg::MODE_ZONE, urlpd_pkg::MODE_QUERY, urlpd_pkg::MODE_PATH};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings, path mode straight out of reset: the byte extremes and a
        // plain escape.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%41", 1'b1);
        // Query mode: plus becomes a space, a broken escape drops the rest of its
        // string, and a string may end halfway through an escape.
        set_mode(urlpd_pkg::MODE_QUERY);
        send_text("+", 1'b1);
        send_text("%zq", 1'b1);
        send_text("%4", 1'b1);
        // Host mode: escaped ASCII is refused unless it is the percent sign, a literal
        // slash is refused, and high bytes pass as they are.
        set_mode(urlpd_pkg::MODE_HOST);
        send_text("%41", 1'b1);
        send_text("%25", 1'b1);
        send_text("/", 1'b1);
        send_byte(8'h80, 1'b1);
        // Zone mode: an escaped space passes, an escaped slash does not.
        set_mode(urlpd_pkg::MODE_ZONE);
        send_text("%20", 1'b1);
        send_text("%2F", 1'b1);
        // The spare mode value decodes as a path.
        set_mode(MODE_SPARE);
        send_text("%7e", 1'b1);

        // Random strings in three idling phases: a slow receiver, a slow sender, then
        // no idling at all, opened by a long result stall that backs the block up.
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 35;
            end
            else if (p == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int s = 0; s < SEGMENTS_PER_PHASE; s++)
            begin
                run_segment(mode_plan[p * SEGMENTS_PER_PHASE + s], (p == 2) && (s == 0));
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (decode_board.expected_words.size() != 0)
        begin
            $display("%0t ns: expected %0d more words, actual none", $time,
                     decode_board.expected_words.size());
            decode_board.mismatches += decode_board.expected_words.size();
        end

        $display("Decoded %0d bytes into %0d checked words across all eight mode values,",
                 decode_board.bytes_taken, decode_board.results_seen);
        $display("under both one-sided idling patterns, none, and a %0d-cycle result stall.",
                 LONG_HOLD);
        if (decode_board.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
